>>> rtl/qmi_pkg.sv
// Shared constants, codes and types for the queue with middle insertion.
package qmi_pkg;

  // Storage geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Word layouts on the stream ports
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_BITS   = OPCODE_W + DATA_W;
  localparam int OUT_BITS  = DATA_W + STATUS_W + CNT_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_MIDDLE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // take the input word and issue store reads
    logic exec;     // apply the operation and load the result register
  } cmd_t;

endpackage

>>> rtl/queue_with_middle_insert.sv
// Top level of the queue with append, middle insert and pop.
//
//  Port group | Role   | tdata fields (low bit first)
//  -----------+--------+---------------------------------------------------
//  s_*        | input  | opcode[1:0], value[33:2], zero fill to 40 bits
//  m_*        | output | popped_value[31:0], status[33:32], occupancy[44:34]
//
// Each word has an accept cycle that reads the head of both half stores and
// an execute cycle that writes at most one entry in each half and loads the
// result register. The next word is taken in idle once that result drains.
// Reset clears the head pointers and counts; the stores need no clearing.
// Input is stalled while a result waits in the output register untaken.
module queue_with_middle_insert (
  input  logic                            clk,
  input  logic                            rst,
  // opcode, value
  input  logic [qmi_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // popped_value, status, occupancy
  output logic [qmi_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready
);
  import qmi_pkg::*;

  cmd_t cmd;

  qmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  qmi_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

  // Every accepted word is followed by a result once it has executed
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> ##1 m_tvalid)
    else $error("no result after accepted word");

  // No second word while one is executing
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted during execute");

  // Occupancy never exceeds the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[DATA_W+STATUS_W +: CNT_W] <= CNT_W'(QUEUE_DEPTH)))
    else $error("occupancy beyond depth");

  // A full report comes only with a full queue
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[DATA_W +: STATUS_W] == ST_FULL))
      |-> (m_tdata[DATA_W+STATUS_W +: CNT_W] == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with room left");

  // An empty report comes with an empty queue and zero data
  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[DATA_W +: STATUS_W] == ST_EMPTY))
      |-> ((m_tdata[DATA_W+STATUS_W +: CNT_W] == '0) && (m_tdata[DATA_W-1:0] == '0)))
    else $error("empty status on non-empty queue");

endmodule

>>> rtl/qmi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/qmi_ctrl.sv
// Controller: sequences accept and execute, owns the handshake flags.
module qmi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output qmi_pkg::cmd_t cmd
);
  import qmi_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;
  logic accept;

  // Take a word only in idle with the result register free or draining
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  assign cmd.capture = accept;
  assign cmd.exec    = (state == ST_EXEC);

  // Advance state and track the result register
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (state == ST_EXEC) begin
      m_tvalid_next = 1'b1;
    end else begin
      m_tvalid_next = m_tvalid && !m_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

>>> rtl/qmi_dp.sv
// Datapath: half-queue stores, head pointers, counts and the result register.
module qmi_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  qmi_pkg::cmd_t                   cmd,
  input  logic [qmi_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic [qmi_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import qmi_pkg::*;

  // Control state: head pointers and counts of both halves
  logic [PTR_W-1:0] front_head, front_head_next;
  logic [PTR_W-1:0] back_head,  back_head_next;
  logic [CNT_W-1:0] front_count, front_count_next;
  logic [CNT_W-1:0] back_count,  back_count_next;

  // Captured operation
  logic [OPCODE_W-1:0] op;
  logic [DATA_W-1:0]   val;

  // Store ports
  logic              front_we, back_we;
  logic [PTR_W-1:0]  front_waddr, back_waddr;
  logic [DATA_W-1:0] front_wdata, back_wdata;
  logic [DATA_W-1:0] front_rdata, back_rdata;

  // Operation decode
  logic [CNT_W-1:0]    total, total_next;
  logic                is_full, is_empty;
  logic                ins_ok, pop_ok, move;
  logic [DATA_W-1:0]   move_data;
  logic [DATA_W-1:0]   popped;
  logic [STATUS_W-1:0] status;

  // Hold the accepted word for the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= s_tdata[OPCODE_W-1:0];
      val <= s_tdata[OPCODE_W +: DATA_W];
    end
  end

  // Front half: read at its head, write at its tail
  qmi_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .wr_en   (front_we),
    .wr_addr (front_waddr),
    .wr_data (front_wdata),
    .rd_en   (cmd.capture),
    .rd_addr (front_head),
    .rd_data (front_rdata)
  );

  // Back half: read at its head, write at either end
  qmi_ram #(.WIDTH(DATA_W), .DEPTH(QUEUE_DEPTH)) u_back (
    .clk     (clk),
    .wr_en   (back_we),
    .wr_addr (back_waddr),
    .wr_data (back_wdata),
    .rd_en   (cmd.capture),
    .rd_addr (back_head),
    .rd_data (back_rdata)
  );

  // Halves stay balanced: front holds as many as back, or one more.
  // Any successful operation on a balanced pair moves one word forward.
  assign total    = CNT_W'(front_count + back_count);
  assign is_full  = (total == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (front_count == '0);
  assign ins_ok   = ((op == OP_APPEND) || (op == OP_MIDDLE)) && !is_full;
  assign pop_ok   = (op == OP_POP) && !is_empty;
  assign move     = (front_count == back_count) && (ins_ok || pop_ok);

  // Forward the new word when it is itself the one that moves
  always_comb begin
    if ((op == OP_MIDDLE) || ((op == OP_APPEND) && (back_count == '0))) begin
      move_data = val;
    end else begin
      move_data = back_rdata;
    end
  end

  // Work out store writes and next pointers
  always_comb begin
    front_head_next  = front_head;
    front_count_next = front_count;
    back_head_next   = back_head;
    back_count_next  = back_count;
    back_we          = 1'b0;
    back_waddr       = PTR_W'(back_head + back_count[PTR_W-1:0]);
    back_wdata       = val;
    popped           = '0;
    status           = ST_OK;

    front_we    = cmd.exec && move;
    front_waddr = PTR_W'(front_head + front_count[PTR_W-1:0]);
    front_wdata = move_data;

    unique case (op)
      OP_APPEND: begin
        if (!ins_ok) begin
          status = ST_FULL;
        end else begin
          back_we = cmd.exec;
          if (move) begin
            front_count_next = CNT_W'(front_count + 1'b1);
            back_head_next   = PTR_W'(back_head + 1'b1);
          end else begin
            back_count_next = CNT_W'(back_count + 1'b1);
          end
        end
      end
      OP_MIDDLE: begin
        if (!ins_ok) begin
          status = ST_FULL;
        end else if (move) begin
          front_count_next = CNT_W'(front_count + 1'b1);
        end else begin
          back_we         = cmd.exec;
          back_waddr      = PTR_W'(back_head - 1'b1);
          back_head_next  = PTR_W'(back_head - 1'b1);
          back_count_next = CNT_W'(back_count + 1'b1);
        end
      end
      OP_POP: begin
        if (!pop_ok) begin
          status = ST_EMPTY;
        end else begin
          popped          = front_rdata;
          front_head_next = PTR_W'(front_head + 1'b1);
          if (move) begin
            back_head_next  = PTR_W'(back_head + 1'b1);
            back_count_next = CNT_W'(back_count - 1'b1);
          end else begin
            front_count_next = CNT_W'(front_count - 1'b1);
          end
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    total_next = CNT_W'(front_count_next + back_count_next);
  end

  // Advance pointers on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      front_head  <= '0;
      front_count <= '0;
      back_head   <= '0;
      back_count  <= '0;
    end else if (cmd.exec) begin
      front_head  <= front_head_next;
      front_count <= front_count_next;
      back_head   <= back_head_next;
      back_count  <= back_count_next;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= OUT_TDATA_W'({total_next, status, popped});
    end
  end

endmodule

>>> dv/qmi_checker.sv
// Checker for the queue with middle insertion: predicts every result word and compares it.
module qmi_checker
  import qmi_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // opcode, value
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // popped_value, status, occupancy
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [DATA_W-1:0]   popped_value;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    occupancy;
  } result_t;

  // Queue contents, head at index 0, and results still owed by the block
  logic [DATA_W-1:0] queue_image[$];
  result_t           expected_results[$];
  int                fail_count = 0;

  assign errors = fail_count;

  // Apply one command word to the queue image and return its result word
  function automatic result_t apply_command(logic [OPCODE_W-1:0] op,
                                            logic [DATA_W-1:0] val);
    result_t r;
    int      n;
    r = '0;
    r.status = ST_OK;
    n = queue_image.size();
    case (op)
      OP_APPEND, OP_MIDDLE: begin
        if (n >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_APPEND) begin
          queue_image.push_back(val);
        end else begin
          // middle slot is ceil(n/2) counted from the head
          queue_image.insert((n + 1) / 2, val);
        end
      end
      OP_POP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_value = queue_image.pop_front();
        end
      end
      default: ;
    endcase
    r.occupancy = CNT_W'(queue_image.size());
    return r;
  endfunction

  task automatic compare_field(string field, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Check result words first: a word accepted on this edge cannot be answered yet
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      queue_image.delete();
      expected_results.delete();
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.popped_value = m_tdata[DATA_W-1:0];
        got.status       = m_tdata[DATA_W +: STATUS_W];
        got.occupancy    = m_tdata[DATA_W+STATUS_W +: CNT_W];
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, m_tdata[OUT_BITS-1:0]);
        end else begin
          want = expected_results.pop_front();
          compare_field("popped_value", want.popped_value, got.popped_value);
          compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
          compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_command(s_tdata[OPCODE_W-1:0],
                                                 s_tdata[OPCODE_W +: DATA_W]));
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> dv/tb_queue_with_middle_insert.sv
// Testbench top for the queue with middle insertion: stimulus, back pressure and verdict.
module tb_queue_with_middle_insert;
  import qmi_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
  localparam int                  CYCLE_LIMIT = 200000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  // opcode, value
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // popped_value, status, occupancy
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  int errors;
  int pending;
  int send_idle = 8;
  int recv_idle = 55;
  int level = 0;
  int cycles = 0;

  queue_with_middle_insert i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  qmi_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one command word, with a random gap ahead of it; valid stays high after
  task automatic send_word(logic [OPCODE_W-1:0] op, logic [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {{(IN_TDATA_W-IN_BITS){1'b0}}, val, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    // track the fill level to steer the random mix
    case (op)
      OP_APPEND, OP_MIDDLE: if (level < QUEUE_DEPTH) level++;
      OP_POP:               if (level > 0) level--;
      default: ;
    endcase
  endtask

  // Hold the input until every owed result word has arrived
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [DATA_W-1:0] random_value();
    case ($urandom_range(19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Send random words: a few unused opcodes, inserts at the given percentage, else pops
  task automatic send_random(int count, int insert_pct);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_word(OP_UNUSED, random_value());
      end else if (pick < 3 + insert_pct) begin
        send_word($urandom_range(1) ? OP_MIDDLE : OP_APPEND, random_value());
      end else begin
        send_word(OP_POP, random_value());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, unused opcode, extremes, middle insert into empty, drain
    send_word(OP_POP, 32'h1234_5678);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(OP_MIDDLE, 32'h8000_0000);
    send_word(OP_APPEND, 32'h7FFF_FFFF);
    send_word(OP_MIDDLE, 32'h0000_0000);
    send_word(OP_APPEND, 32'hFFFF_FFFF);
    send_word(OP_MIDDLE, 32'h0000_0001);
    send_word(OP_APPEND, 32'h5555_5555);
    send_word(OP_MIDDLE, 32'hAAAA_AAAA);
    send_word(OP_UNUSED, 32'h0F0F_0F0F);
    send_word(OP_POP, 32'hFFFF_FFFF);
    send_word(OP_MIDDLE, 32'hDEAD_BEEF);
    repeat (8) send_word(OP_POP, 32'h0000_0000);
    send_word(OP_POP, 32'h8000_0000);

    // Random near empty, then let everything drain before the next phase
    send_random(100, 47);
    wait_drained();

    send_idle = 55;
    recv_idle = 8;
    send_random(100, 85);

    // No idling: fill up to capacity, then hover around full
    send_idle = 0;
    recv_idle = 0;
    while (level < QUEUE_DEPTH) send_random(1, 95);
    send_random(40, 48);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> queue_with_middle_insert.f
rtl/qmi_pkg.sv
rtl/qmi_ram.sv
rtl/qmi_ctrl.sv
rtl/qmi_dp.sv
rtl/queue_with_middle_insert.sv
dv/qmi_checker.sv
dv/tb_queue_with_middle_insert.sv
